// ===== src/rtw_pkg.sv =====
// ----------------------------------------------------------------------------
// rtw_pkg: shared types and constants for the range-to-world rotate core
// Field widths, register indexes and the quarter-wave sine generator.
// ----------------------------------------------------------------------------
package rtw_pkg;

    // Stream field widths
    localparam int RANGE_W     = 16;
    localparam int HEADING_W   = 16;
    localparam int POS_W       = 17;
    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 40;
    localparam int OUT_PAD_W   = OUT_TDATA_W - 2 * POS_W;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 14;
    localparam int TOL_W      = 14;

    localparam logic [CFG_IDX_W-1:0] REG_SIDE_SELECT   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CARDINAL_TOL  = 1'd1;
    localparam logic [TOL_W-1:0]     TOL_RESET         = 14'd1820;

    // Q1.15 arithmetic
    localparam int              TRIG_W     = 16;
    localparam int unsigned     ROUND_HALF = 16384;
    localparam logic [POS_W-1:0] POS_MAX   = 17'd131071;

    // pi/2 in Q30
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned Q15_ONE     = 64'd32768;

    // Control bits that travel with a transaction after the table lookup
    typedef struct packed {
        logic sin_neg;
        logic cos_neg;
        logic scale_en;
    } t_trig_ctl;

    // One quarter-wave sine entry: Taylor series in Q30, rounded to Q15.
    // Evaluated at elaboration only, to fill the constant table.
    function automatic logic [TRIG_W-1:0] sine_q15(input int unsigned k,
                                                   input int unsigned tb);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned prod;
        longint unsigned q;
        longint          sum;
        int              n;
        x = (longint'(k) * HALF_PI_Q30 + (64'd1 << (tb - 1))) >> tb;
        x2 = (x * x) >> 30;
        term = x;
        sum = longint'(x);
        for (n = 1; n <= 7; n++) begin
            prod = (term * x2) >> 30;
            case (n)
                1:       term = prod / 6;
                2:       term = prod / 20;
                3:       term = prod / 42;
                4:       term = prod / 72;
                5:       term = prod / 110;
                6:       term = prod / 156;
                default: term = prod / 210;
            endcase
            if ((n % 2) == 1) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        q = (longint'(sum) + 64'd16384) >> 15;
        if (q > Q15_ONE) begin
            q = Q15_ONE;
        end
        return q[TRIG_W-1:0];
    endfunction

endpackage

// ===== src/rtw_sine_rom.sv =====
// ----------------------------------------------------------------------------
// rtw_sine_rom: quarter-wave sine table with registered read
// 2^TRIG_TABLE_BITS+1 entries covering [0, pi/2], unsigned Q1.15.
// ----------------------------------------------------------------------------
module rtw_sine_rom #(
    parameter int TRIG_TABLE_BITS = 10
) (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [TRIG_TABLE_BITS:0]    i_addr,
    output logic [rtw_pkg::TRIG_W-1:0]  o_data
);

    localparam int unsigned TAB_N = 1 << TRIG_TABLE_BITS;

    logic [rtw_pkg::TRIG_W-1:0] w_rom [TAB_N+1];
    logic [rtw_pkg::TRIG_W-1:0] r_data;

    // constant table, folded at elaboration
    for (genvar k = 0; k <= TAB_N; k++) begin : g_rom
        assign w_rom[k] = rtw_pkg::sine_q15(k, TRIG_TABLE_BITS);
    end

    // registered read, held on stall
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= w_rom[i_addr];
        end
    end

    assign o_data = r_data;

endmodule

// ===== src/rtw_trig_lookup.sv =====
// ----------------------------------------------------------------------------
// rtw_trig_lookup: angle reduction and table lookup stage
// Finds the deviation from the nearest cardinal angle, decides on cosine
// scaling and reads sine, cosine and the correction factor from the table.
// ----------------------------------------------------------------------------
module rtw_trig_lookup #(
    parameter int ANGLE_BITS      = 16,
    parameter int TRIG_TABLE_BITS = 10,
    parameter int RANGE_W         = 16
) (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [rtw_pkg::TOL_W-1:0]   i_tol,
    input  logic [ANGLE_BITS-1:0]       i_angle,
    input  logic [RANGE_W-1:0]          i_side,
    input  logic [RANGE_W-1:0]          i_front,
    output logic [RANGE_W-1:0]          o_side,
    output logic [RANGE_W-1:0]          o_front,
    output logic [rtw_pkg::TRIG_W-1:0]  o_cf,
    output logic [rtw_pkg::TRIG_W-1:0]  o_smag,
    output logic [rtw_pkg::TRIG_W-1:0]  o_cmag,
    output rtw_pkg::t_trig_ctl          o_ctl
);

    localparam int QB    = ANGLE_BITS - 2;
    localparam int TB    = TRIG_TABLE_BITS;
    localparam int DIFF  = QB - TB;
    localparam int SH_R  = (DIFF > 0) ? DIFF : 0;
    localparam int SH_L  = (DIFF < 0) ? -DIFF : 0;
    localparam int RND   = (DIFF > 0) ? (1 << (SH_R - 1)) : 0;
    localparam int WW    = QB + 2 + SH_L;
    localparam int CW    = (QB + 1 > rtw_pkg::TOL_W) ? QB + 1 : rtw_pkg::TOL_W;

    localparam logic [QB:0] QTR   = {1'b1, {QB{1'b0}}};
    localparam logic [TB:0] TAB_N = {1'b1, {TB{1'b0}}};

    // quadrant position to table index: round half up to or widen up to TB bits
    function automatic logic [TB:0] tab_index(input logic [QB:0] v);
        logic [WW-1:0] t;
        t = (WW'(v) + WW'(RND)) >> SH_R;
        t = t << SH_L;
        return (t > WW'(TAB_N)) ? TAB_N : t[TB:0];
    endfunction

    logic [QB-1:0]      w_p;
    logic [QB:0]        w_qmp;
    logic [QB:0]        w_dev;
    logic [1:0]         w_quad;
    logic [1:0]         w_quad_c;
    logic [TB:0]        w_idx;
    logic [TB:0]        w_sin_addr;
    logic [TB:0]        w_cos_addr;
    logic [TB:0]        w_cf_addr;
    logic               w_scale;

    logic [RANGE_W-1:0] r_side;
    logic [RANGE_W-1:0] r_front;
    rtw_pkg::t_trig_ctl r_ctl;

    // deviation from the nearest multiple of 90 degrees
    assign w_p     = i_angle[QB-1:0];
    assign w_qmp   = QTR - {1'b0, w_p};
    assign w_dev   = ({1'b0, w_p} < w_qmp) ? {1'b0, w_p} : w_qmp;
    assign w_scale = (CW'(w_dev) >= CW'(i_tol));

    // sine and cosine addresses; cosine is the next quadrant up
    assign w_quad     = i_angle[ANGLE_BITS-1:ANGLE_BITS-2];
    assign w_quad_c   = w_quad + 2'd1;
    assign w_idx      = tab_index({1'b0, w_p});
    assign w_sin_addr = w_quad[0]   ? (TAB_N - w_idx) : w_idx;
    assign w_cos_addr = w_quad_c[0] ? (TAB_N - w_idx) : w_idx;
    assign w_cf_addr  = TAB_N - tab_index(w_dev);

    rtw_sine_rom #(.TRIG_TABLE_BITS(TB)) u_rom_sin (
        .i_clk  (i_clk),
        .i_en   (i_en),
        .i_addr (w_sin_addr),
        .o_data (o_smag)
    );

    rtw_sine_rom #(.TRIG_TABLE_BITS(TB)) u_rom_cos (
        .i_clk  (i_clk),
        .i_en   (i_en),
        .i_addr (w_cos_addr),
        .o_data (o_cmag)
    );

    rtw_sine_rom #(.TRIG_TABLE_BITS(TB)) u_rom_cf (
        .i_clk  (i_clk),
        .i_en   (i_en),
        .i_addr (w_cf_addr),
        .o_data (o_cf)
    );

    // payload alongside the table read
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side           <= i_side;
            r_front          <= i_front;
            r_ctl.sin_neg    <= w_quad[1];
            r_ctl.cos_neg    <= w_quad_c[1];
            r_ctl.scale_en   <= w_scale;
        end
    end

    assign o_side  = r_side;
    assign o_front = r_front;
    assign o_ctl   = r_ctl;

endmodule

// ===== src/rtw_rotate.sv =====
// ----------------------------------------------------------------------------
// rtw_rotate: cosine scaling, rotation and output rounding
// Three register stages: scaled ranges, four products, signed sums. The
// magnitude rounding and saturation are left for the output register.
// ----------------------------------------------------------------------------
module rtw_rotate #(
    parameter int RANGE_W = 16
) (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [RANGE_W-1:0]          i_side,
    input  logic [RANGE_W-1:0]          i_front,
    input  logic [rtw_pkg::TRIG_W-1:0]  i_cf,
    input  logic [rtw_pkg::TRIG_W-1:0]  i_smag,
    input  logic [rtw_pkg::TRIG_W-1:0]  i_cmag,
    input  rtw_pkg::t_trig_ctl          i_ctl,
    output logic [rtw_pkg::POS_W-1:0]   o_pos_x,
    output logic [rtw_pkg::POS_W-1:0]   o_pos_y
);

    localparam int TW = rtw_pkg::TRIG_W;
    localparam int PW = RANGE_W + TW;      // product width
    localparam int SW = PW + 2;            // signed sum width
    localparam int RW = SW - 14;           // rounded magnitude width
    localparam int MW = (RW > rtw_pkg::POS_W) ? RW : rtw_pkg::POS_W;

    // stage A: cosine correction
    logic [PW:0]           w_front_p;
    logic [PW:0]           w_side_p;
    logic [RANGE_W-1:0]    r_front;
    logic [RANGE_W-1:0]    r_side;
    logic [TW-1:0]         r_smag;
    logic [TW-1:0]         r_cmag;
    logic                  r_sin_neg;
    logic                  r_cos_neg;

    assign w_front_p = (PW + 1)'(i_front * i_cf) + (PW + 1)'(rtw_pkg::ROUND_HALF);
    assign w_side_p  = (PW + 1)'(i_side * i_cf)  + (PW + 1)'(rtw_pkg::ROUND_HALF);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_front   <= i_ctl.scale_en ? w_front_p[RANGE_W+14:15] : i_front;
            r_side    <= i_ctl.scale_en ? w_side_p[RANGE_W+14:15]  : i_side;
            r_smag    <= i_smag;
            r_cmag    <= i_cmag;
            r_sin_neg <= i_ctl.sin_neg;
            r_cos_neg <= i_ctl.cos_neg;
        end
    end

    // stage B: four rotation products, magnitudes with signs alongside
    logic [PW-1:0] r_fc;
    logic [PW-1:0] r_ss;
    logic [PW-1:0] r_fs;
    logic [PW-1:0] r_sc;
    logic          r_b_sin_neg;
    logic          r_b_cos_neg;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_fc        <= PW'(r_front * r_cmag);
            r_ss        <= PW'(r_side  * r_smag);
            r_fs        <= PW'(r_front * r_smag);
            r_sc        <= PW'(r_side  * r_cmag);
            r_b_sin_neg <= r_sin_neg;
            r_b_cos_neg <= r_cos_neg;
        end
    end

    // stage C: signed sums, x = f*c - s*sin, y = f*sin + s*c
    logic signed [SW-1:0] w_fc;
    logic signed [SW-1:0] w_ss;
    logic signed [SW-1:0] w_fs;
    logic signed [SW-1:0] w_sc;
    logic signed [SW-1:0] r_x;
    logic signed [SW-1:0] r_y;

    assign w_fc = r_b_cos_neg ? -signed'(SW'(r_fc)) : signed'(SW'(r_fc));
    assign w_ss = r_b_sin_neg ? -signed'(SW'(r_ss)) : signed'(SW'(r_ss));
    assign w_fs = r_b_sin_neg ? -signed'(SW'(r_fs)) : signed'(SW'(r_fs));
    assign w_sc = r_b_cos_neg ? -signed'(SW'(r_sc)) : signed'(SW'(r_sc));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x <= w_fc - w_ss;
            r_y <= w_fs + w_sc;
        end
    end

    // magnitude, round half up, saturate (feeds the output register)
    logic [SW-1:0] w_x_mag;
    logic [SW-1:0] w_y_mag;
    logic [SW:0]   w_x_rnd;
    logic [SW:0]   w_y_rnd;
    logic [MW-1:0] w_x_ext;
    logic [MW-1:0] w_y_ext;

    assign w_x_mag = r_x[SW-1] ? SW'(-r_x) : SW'(r_x);
    assign w_y_mag = r_y[SW-1] ? SW'(-r_y) : SW'(r_y);
    assign w_x_rnd = (SW + 1)'(w_x_mag) + (SW + 1)'(rtw_pkg::ROUND_HALF);
    assign w_y_rnd = (SW + 1)'(w_y_mag) + (SW + 1)'(rtw_pkg::ROUND_HALF);
    assign w_x_ext = MW'(w_x_rnd[SW:15]);
    assign w_y_ext = MW'(w_y_rnd[SW:15]);

    assign o_pos_x = (w_x_ext > MW'(rtw_pkg::POS_MAX)) ? rtw_pkg::POS_MAX
                                                       : w_x_ext[rtw_pkg::POS_W-1:0];
    assign o_pos_y = (w_y_ext > MW'(rtw_pkg::POS_MAX)) ? rtw_pkg::POS_MAX
                                                       : w_y_ext[rtw_pkg::POS_W-1:0];

endmodule

// ===== src/range_to_world_rotate_core.sv =====
// ----------------------------------------------------------------------------
// range_to_world_rotate_core: range readings to absolute world offsets
// Throughput: one transaction per cycle while the skid register is empty, set
//   by a fully pipelined datapath (input register, table read, scaling,
//   products, sums, output register).
// A skid register lets input continue while a result waits on the output.
// Reset (synchronous, active low) clears valid bits and loads register
//   defaults: side_select 0, cardinal_tolerance 1820.
// ----------------------------------------------------------------------------
module range_to_world_rotate_core #(
    parameter int RANGE_BITS      = 16,
    parameter int ANGLE_BITS      = 16,
    parameter int TRIG_TABLE_BITS = 10
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // slave stream
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // tdata: side_range_a[15:0], side_range_b[31:16], front_range[47:32],
    //        heading[63:48]
    input  logic [rtw_pkg::IN_TDATA_W-1:0]      i_s_tdata,
    // master stream
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // tdata: pos_x[16:0], pos_y[33:17], zero[39:34]
    output logic [rtw_pkg::OUT_TDATA_W-1:0]     o_m_tdata,
    // configuration write port
    input  logic                                i_cfg_wr_en,
    input  logic [rtw_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [rtw_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int RW = (RANGE_BITS < rtw_pkg::RANGE_W) ? RANGE_BITS : rtw_pkg::RANGE_W;
    localparam int HW = rtw_pkg::HEADING_W;
    localparam int PW = rtw_pkg::POS_W;

    // configuration registers
    logic                       r_side_sel;
    logic [rtw_pkg::TOL_W-1:0]  r_card_tol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side_sel <= 1'b0;
            r_card_tol <= rtw_pkg::TOL_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                rtw_pkg::REG_SIDE_SELECT:  r_side_sel <= i_cfg_data[0];
                rtw_pkg::REG_CARDINAL_TOL: r_card_tol <= i_cfg_data[rtw_pkg::TOL_W-1:0];
                default: ;
            endcase
        end
    end

    // pipeline advances unless a result is parked in the skid register
    logic w_en;
    logic r_skid_vld;
    logic [4:0] r_vld;

    assign w_en       = !r_skid_vld;
    assign o_s_tready = w_en;

    // input field unpack
    logic [HW-1:0]           w_side_a;
    logic [HW-1:0]           w_side_b;
    logic [HW-1:0]           w_front;
    logic [HW-1:0]           w_heading;
    logic [ANGLE_BITS+HW-1:0] w_head_ext;

    assign w_side_a   = i_s_tdata[15:0];
    assign w_side_b   = i_s_tdata[31:16];
    assign w_front    = i_s_tdata[47:32];
    assign w_heading  = i_s_tdata[63:48];
    assign w_head_ext = {{ANGLE_BITS{w_heading[HW-1]}}, w_heading};

    // stage 1: input register
    logic [RW-1:0]         r_side;
    logic [RW-1:0]         r_front;
    logic [ANGLE_BITS-1:0] r_angle;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_side  <= r_side_sel ? w_side_b[RW-1:0] : w_side_a[RW-1:0];
            r_front <= w_front[RW-1:0];
            r_angle <= w_head_ext[ANGLE_BITS-1:0];
        end
    end

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[3:0], i_s_tvalid};
        end
    end

    // stage 2: table lookup
    logic [RW-1:0]                 w_l_side;
    logic [RW-1:0]                 w_l_front;
    logic [rtw_pkg::TRIG_W-1:0]    w_cf;
    logic [rtw_pkg::TRIG_W-1:0]    w_smag;
    logic [rtw_pkg::TRIG_W-1:0]    w_cmag;
    rtw_pkg::t_trig_ctl            w_ctl;

    rtw_trig_lookup #(
        .ANGLE_BITS      (ANGLE_BITS),
        .TRIG_TABLE_BITS (TRIG_TABLE_BITS),
        .RANGE_W         (RW)
    ) u_lookup (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_tol   (r_card_tol),
        .i_angle (r_angle),
        .i_side  (r_side),
        .i_front (r_front),
        .o_side  (w_l_side),
        .o_front (w_l_front),
        .o_cf    (w_cf),
        .o_smag  (w_smag),
        .o_cmag  (w_cmag),
        .o_ctl   (w_ctl)
    );

    // stages 3 to 5: scaling, products, sums
    logic [PW-1:0] w_pos_x;
    logic [PW-1:0] w_pos_y;

    rtw_rotate #(.RANGE_W(RW)) u_rotate (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_side  (w_l_side),
        .i_front (w_l_front),
        .i_cf    (w_cf),
        .i_smag  (w_smag),
        .i_cmag  (w_cmag),
        .i_ctl   (w_ctl),
        .o_pos_x (w_pos_x),
        .o_pos_y (w_pos_y)
    );

    // output register and skid register
    logic              r_out_vld;
    logic [PW-1:0]     r_out_x;
    logic [PW-1:0]     r_out_y;
    logic [PW-1:0]     r_skid_x;
    logic [PW-1:0]     r_skid_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            // pipeline frozen; drain the parked transaction first
            if (i_m_tready) begin
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end
        end else if (!r_out_vld || i_m_tready) begin
            r_out_vld <= r_vld[4];
        end else if (r_vld[4]) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (i_m_tready) begin
                r_out_x <= r_skid_x;
                r_out_y <= r_skid_y;
            end
        end else if (!r_out_vld || i_m_tready) begin
            r_out_x <= w_pos_x;
            r_out_y <= w_pos_y;
        end else begin
            r_skid_x <= w_pos_x;
            r_skid_y <= w_pos_y;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {{rtw_pkg::OUT_PAD_W{1'b0}}, r_out_y, r_out_x};

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for range_to_world_rotate_core
// Drives range readings and headings on the input stream and predicts each
// world offset from its own quarter-wave sine table. Results are compared
// field by field against the oldest outstanding prediction. Covers cardinal
// and diagonal headings, both side ranges, extreme tolerances, back-pressure
// and random traffic with random gaps on both sides.
// ----------------------------------------------------------------------------
module testbench;

    localparam int TABLE_N      = 1024;
    localparam int IDX_SHIFT    = 4;
    localparam int QUARTER      = 16384;
    localparam int HOLD_CYCLES  = 64;
    localparam int DRAIN_CYCLES = 8;
    localparam int SEG_ITEMS    = 180;

    // one reading as carried on the input stream
    typedef struct packed {
        logic [rtw_pkg::RANGE_W-1:0]   side_a;
        logic [rtw_pkg::RANGE_W-1:0]   side_b;
        logic [rtw_pkg::RANGE_W-1:0]   front;
        logic [rtw_pkg::HEADING_W-1:0] heading;
    } reading_t;

    typedef struct packed {
        logic [rtw_pkg::POS_W-1:0] pos_x;
        logic [rtw_pkg::POS_W-1:0] pos_y;
    } position_t;

    logic                            i_clk       = 1'b0;
    logic                            i_rst_n     = 1'b0;
    logic                            i_s_tvalid  = 1'b0;
    logic                            o_s_tready;
    logic [rtw_pkg::IN_TDATA_W-1:0]  i_s_tdata   = '0;
    logic                            o_m_tvalid;
    logic                            i_m_tready  = 1'b0;
    logic [rtw_pkg::OUT_TDATA_W-1:0] o_m_tdata;
    logic                            i_cfg_wr_en = 1'b0;
    logic [rtw_pkg::CFG_IDX_W-1:0]   i_cfg_idx   = '0;
    logic [rtw_pkg::CFG_DATA_W-1:0]  i_cfg_data  = '0;

    // predictor copy of the registers
    logic      side_sel    = 1'b0;
    int        tol_setting = rtw_pkg::TOL_RESET;

    longint    quarter_sine [0:TABLE_N];
    position_t pending_positions [$];

    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    int hold_reqs     = 0;
    int mismatches    = 0;

    range_to_world_rotate_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // quarter-wave sine, Q1.15, from a Q30 Taylor series
    initial begin : sine_table
        longint unsigned ang;
        longint unsigned ang_sq;
        longint unsigned term;
        longint          acc;
        for (int k = 0; k <= TABLE_N; k++) begin
            ang = k;
            ang = (ang * rtw_pkg::HALF_PI_Q30 + TABLE_N / 2) / TABLE_N;
            ang_sq = (ang * ang) >> 30;
            term = ang;
            acc = ang;
            for (int n = 1; n <= 7; n++) begin
                term = ((term * ang_sq) >> 30) / ((2 * n) * (2 * n + 1));
                if (n % 2 == 1) begin
                    acc = acc - term;
                end else begin
                    acc = acc + term;
                end
            end
            if (acc < 0) begin
                acc = 0;
            end
            acc = (acc + 16384) >>> 15;
            quarter_sine[k] = (acc > 32768) ? 32768 : acc;
        end
    end

    // angle within a quadrant down to a table index, rounded half up
    function automatic int quarter_index(input int unsigned phase);
        int unsigned idx;
        idx = (phase + (1 << (IDX_SHIFT - 1))) >> IDX_SHIFT;
        return (idx > TABLE_N) ? TABLE_N : idx;
    endfunction

    function automatic longint sine_of(input logic [15:0] ang);
        int     idx;
        longint mag;
        idx = quarter_index(ang[13:0]);
        mag = ang[14] ? quarter_sine[TABLE_N - idx] : quarter_sine[idx];
        return ang[15] ? -mag : mag;
    endfunction

    function automatic logic [rtw_pkg::POS_W-1:0] round_magnitude(input longint v);
        longint m;
        m = (v < 0) ? -v : v;
        m = (m + 16384) >>> 15;
        return (m > rtw_pkg::POS_MAX) ? rtw_pkg::POS_MAX : m[rtw_pkg::POS_W-1:0];
    endfunction

    // expected world offset for one reading under the current settings
    function automatic position_t predict_position(input reading_t r);
        longint      side;
        longint      front;
        longint      cf;
        longint      s;
        longint      c;
        int          phase;
        int          dev;
        logic [15:0] cos_ang;
        position_t   res;
        side = side_sel ? r.side_b : r.side_a;
        front = r.front;
        phase = r.heading[13:0];
        dev = (phase < QUARTER - phase) ? phase : QUARTER - phase;
        // off-cardinal: shrink both ranges by cos(deviation)
        if (dev >= tol_setting) begin
            cf = quarter_sine[TABLE_N - quarter_index(dev)];
            front = (front * cf + 16384) >>> 15;
            side = (side * cf + 16384) >>> 15;
        end
        cos_ang = r.heading + 16'd16384;
        s = sine_of(r.heading);
        c = sine_of(cos_ang);
        res.pos_x = round_magnitude(front * c - side * s);
        res.pos_y = round_magnitude(front * s + side * c);
        return res;
    endfunction

    // one input transaction, with random gaps before it
    task automatic send_reading(input logic [15:0] a, input logic [15:0] b,
                                input logic [15:0] f, input logic [15:0] h);
        reading_t r;
        r = '{side_a: a, side_b: b, front: f, heading: h};
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_s_tvalid <= 1'b0;
            i_s_tdata <= {$urandom, $urandom};
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= {r.heading, r.front, r.side_b, r.side_a};
        @(posedge i_clk);
        while (!o_s_tready) begin
            @(posedge i_clk);
        end
        pending_positions.push_back(predict_position(r));
    endtask

    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        while (pending_positions.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // register write, only once the pipeline is empty
    task automatic write_reg(input logic [rtw_pkg::CFG_IDX_W-1:0] idx,
                             input logic [rtw_pkg::CFG_DATA_W-1:0] val);
        drain_results();
        i_cfg_wr_en <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        if (idx == rtw_pkg::REG_SIDE_SELECT) begin
            side_sel = val[0];
        end else if (idx == rtw_pkg::REG_CARDINAL_TOL) begin
            tol_setting = val;
        end
    endtask

    function automatic logic [15:0] pick_range();
        case ($urandom_range(0, 5))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(0, 255));
            default: return 16'($urandom);
        endcase
    endfunction

    // mostly near the cardinals and diagonals, where the corrections change
    function automatic logic [15:0] pick_heading();
        int          span;
        logic [15:0] base;
        base = {2'($urandom_range(0, 3)), 14'd0};
        span = (tol_setting < 8190) ? tol_setting + 2 : 8192;
        case ($urandom_range(0, 4))
            0:       return base;
            1:       return base + 16'(int'($urandom_range(0, 2 * span)) - span);
            2:       return base + 16'd8192 + 16'(int'($urandom_range(0, 32)) - 16);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [rtw_pkg::CFG_DATA_W-1:0] pick_tolerance();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return rtw_pkg::TOL_RESET;
            2:       return 14'd8192;
            3:       return 14'h3FFF;
            default: return 14'($urandom_range(0, 8192));
        endcase
    endfunction

    // reset settings: cardinals (180 degrees too), tolerance edge, diagonals
    task automatic test_cardinal_headings();
        send_reading(16'd1000, 16'd7, 16'd2000, 16'd0);
        send_reading(16'd1000, 16'd7, 16'd2000, 16'd16384);
        send_reading(16'd1000, 16'd7, 16'd2000, 16'h8000);
        send_reading(16'd1000, 16'd7, 16'd2000, 16'hC000);
        send_reading(16'd3000, 16'd9, 16'd500, 16'd1819);
        send_reading(16'd3000, 16'd9, 16'd500, 16'd1820);
        send_reading(16'd3000, 16'd9, 16'd500, -16'sd1820);
        send_reading(16'd3000, 16'd9, 16'd500, 16'd18204);
        send_reading(16'hFFFF, 16'd0, 16'hFFFF, 16'd8192);
        send_reading(16'hFFFF, 16'd0, 16'hFFFF, -16'sd8192);
        send_reading(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h7FFF);
        send_reading(16'd0, 16'hFFFF, 16'd0, 16'h8001);
    endtask

    task automatic test_side_select();
        write_reg(rtw_pkg::REG_SIDE_SELECT, 14'd1);
        send_reading(16'hFFFF, 16'd0, 16'd1234, 16'd4000);
        send_reading(16'd0, 16'hFFFF, 16'd1234, 16'd0);
        send_reading(16'd111, 16'd4321, 16'hFFFF, 16'hA000);
    endtask

    // zero tolerance corrects even exact cardinals; above 8192 corrects none
    task automatic test_tolerance_limits();
        write_reg(rtw_pkg::REG_CARDINAL_TOL, 14'd0);
        send_reading(16'd5000, 16'd6000, 16'd7000, 16'd0);
        send_reading(16'd5000, 16'd6000, 16'd7000, 16'd100);
        write_reg(rtw_pkg::REG_CARDINAL_TOL, 14'd8192);
        send_reading(16'd5000, 16'd6000, 16'd7000, 16'd8192);
        send_reading(16'd5000, 16'd6000, 16'd7000, 16'd8191);
        write_reg(rtw_pkg::REG_CARDINAL_TOL, 14'h3FFF);
        send_reading(16'd5000, 16'd6000, 16'd7000, 16'd8192);
        write_reg(rtw_pkg::REG_CARDINAL_TOL, rtw_pkg::TOL_RESET);
    endtask

    // output held off while input keeps coming, so the core must stall
    task automatic test_output_backpressure();
        src_idle_pct = 0;
        sink_idle_pct = 0;
        hold_reqs++;
        repeat (60) send_reading(pick_range(), pick_range(), pick_range(), pick_heading());
    endtask

    task automatic test_random_traffic(input int src_pct, input int sink_pct);
        src_idle_pct = src_pct;
        sink_idle_pct = sink_pct;
        repeat (2) begin
            write_reg(rtw_pkg::REG_SIDE_SELECT, 14'($urandom_range(0, 1)));
            write_reg(rtw_pkg::REG_CARDINAL_TOL, pick_tolerance());
            repeat (SEG_ITEMS) begin
                send_reading(pick_range(), pick_range(), pick_range(), pick_heading());
            end
        end
    endtask

    // output side: check each transaction, then choose the next ready
    always @(posedge i_clk) begin : result_sink
        position_t want;
        position_t got;
        int        hold_left;
        int        hold_served;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                got.pos_x = o_m_tdata[rtw_pkg::POS_W-1:0];
                got.pos_y = o_m_tdata[2*rtw_pkg::POS_W-1:rtw_pkg::POS_W];
                if (pending_positions.size() == 0) begin
                    $display("%0t: unexpected result x=%0d y=%0d", $time, got.pos_x,
                             got.pos_y);
                    mismatches++;
                end else begin
                    want = pending_positions.pop_front();
                    if (got.pos_x !== want.pos_x) begin
                        $display("%0t: pos_x expected %0d got %0d", $time, want.pos_x,
                                 got.pos_x);
                        mismatches++;
                    end
                    if (got.pos_y !== want.pos_y) begin
                        $display("%0t: pos_y expected %0d got %0d", $time, want.pos_y,
                                 got.pos_y);
                        mismatches++;
                    end
                    if (o_m_tdata[rtw_pkg::OUT_TDATA_W-1 -: rtw_pkg::OUT_PAD_W] !== '0) begin
                        $display("%0t: padding expected 0 got %0h", $time,
                                 o_m_tdata[rtw_pkg::OUT_TDATA_W-1 -: rtw_pkg::OUT_PAD_W]);
                        mismatches++;
                    end
                end
            end
            if (hold_served != hold_reqs) begin
                hold_served = hold_reqs;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
            end
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_cardinal_headings();
        test_side_select();
        test_tolerance_limits();
        test_output_backpressure();
        test_random_traffic(6, 74);
        test_random_traffic(74, 6);
        test_random_traffic(0, 0);
        drain_results();
        if (mismatches == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

    // watchdog
    initial begin
        #4000000;
        $display("testbench: done, errors");
        $finish;
    end

endmodule

// ===== range_to_world_rotate_core.f =====
src/rtw_pkg.sv
src/rtw_sine_rom.sv
src/rtw_trig_lookup.sv
src/rtw_rotate.sv
src/range_to_world_rotate_core.sv
tb/testbench.sv
